[sv/positional_list_engine_unit_defines.svh]
// Assertion macros for the checker file of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PLE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names.
`define PLE_ASSERT(lbl, prop, msg) \
  `PLE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[sv/plist_pkg.sv]
// Types and codes of the positional list engine.
package plist_pkg;

  // Request modes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  // Response status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // One request transaction.
  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  // One response transaction.
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] found_position;
    logic [4:0] entry_count;
  } rsp_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic               insert;
    logic               remove;
    logic [4:0]         position;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

[sv/plist_cell.sv]
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
module plist_cell import plist_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] entry_o,
  output logic               match_o
);

  localparam logic [31:0] Idx = 32'(CellIdx);

  logic signed [31:0] entry_q, entry_d;
  logic [31:0]        pos;

  assign pos = 32'(ctl_i.position);

  // Insert loads at its own place and shifts back behind it; remove pulls from the right.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (Idx + 32'd1 == pos) begin
        entry_d = ctl_i.value;
      end else if (Idx >= pos) begin
        entry_d = left_i;
      end
    end else if (ctl_i.remove) begin
      if (Idx + 32'd1 >= pos) begin
        entry_d = right_i;
      end
    end
  end

  // Entry storage holds data only, so it has no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == ctl_i.value);

endmodule

[sv/positional_list_engine_unit.sv]
// Top level of the positional list engine: a chain of entry cells plus request control.
//
//   Channel | Direction | Handshake             | Payload
//   in      | input     | in_valid_i/in_stall_o | in_req_i  (req_t)
//   out     | output    | out_valid_o/out_stall_i| out_rsp_o (rsp_t)
//
// Each request completes at once: all cells shift or compare in parallel,
// and the response lands in the output register at the accepting edge.
// Reset clears the entry count and the output valid; entry data is not reset.
// The input stalls only while a response waits in the output register and the
// output side stalls; one request per cycle is taken otherwise.
module positional_list_engine_unit import plist_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > 5) ? CntW + 1 : 6;

  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  rsp_t               out_rsp_q, rsp_d;
  logic               accept;
  cell_ctl_t          ctl;
  logic [CmpW-1:0]    pos_x, cnt_x;
  logic [DEPTH-1:0]   hit, first_hit;
  logic               any_hit;
  logic [4:0]         found;
  logic signed [31:0] entry_w [DEPTH];
  logic [DEPTH-1:0]   match_w;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign pos_x = CmpW'(in_req_i.position);
  assign cnt_x = CmpW'(count_q);

  // Cell chain: each cell sees its left and right neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = ctl.value;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    plist_cell #(.CellIdx(g)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .match_o (match_w[g])
    );
    // Only live entries take part in a search.
    assign hit[g] = match_w[g] & (g < int'(count_q));
  end

  // Lowest matching cell, then its one-based position.
  assign first_hit = hit & (~hit + DEPTH'(1));
  assign any_hit   = |hit;

  always_comb begin
    found = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | (first_hit[i] ? 5'(i + 1) : 5'd0);
    end
  end

  // Request decode: status, cell control and next count.
  always_comb begin
    ctl          = '0;
    ctl.position = in_req_i.position;
    ctl.value    = in_req_i.value;
    count_d      = count_q;
    rsp_d        = '0;
    rsp_d.status = ST_BAD_POS;
    unique case (in_req_i.mode)
      MODE_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + CmpW'(1)) begin
          rsp_d.status = ST_BAD_POS;
        end else if (count_q == CntW'(DEPTH)) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status = ST_OK;
          ctl.insert   = accept;
          count_d      = count_q + CntW'(1);
        end
      end
      MODE_REMOVE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          rsp_d.status = ST_BAD_POS;
        end else begin
          rsp_d.status = ST_OK;
          ctl.remove   = accept;
          count_d      = count_q - CntW'(1);
        end
      end
      MODE_FIND: begin
        if (count_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (any_hit) begin
          rsp_d.status         = ST_OK;
          rsp_d.found_position = found;
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.status = ST_BAD_POS;
      end
    endcase
    rsp_d.entry_count = 5'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (!in_stall_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[sv/plist_checker.sv]
// Port-level checker for the positional list engine and its bind.
`include "positional_list_engine_unit_defines.svh"

module plist_checker import plist_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  logic out_held, in_held, found_any, found_ok, full_rsp, at_depth;

  // Handshake and response conditions sampled by the properties below.
  assign out_held  = out_valid_o && out_stall_i;
  assign in_held   = in_valid_i && in_stall_o;
  assign found_any = out_valid_o && (out_rsp_o.found_position != 5'd0);
  assign found_ok  = (out_rsp_o.status == ST_OK);
  assign full_rsp  = out_valid_o && (out_rsp_o.status == ST_FULL);
  assign at_depth  = (out_rsp_o.entry_count == 5'(DEPTH));

  // A held response stays valid.
  `PLE_ASSERT(a_out_hold, out_held |=> out_valid_o, "response dropped while stalled")

  // A stalled request stays offered and unchanged.
  `PLE_ASSERT(a_in_hold, in_held |=> in_valid_i && $stable(in_req_i), "request moved while stalled")

  // The input stalls only behind a waiting response.
  `PLE_ASSERT(a_stall_cause, in_stall_o |-> out_held, "input stalled without cause")

  // A found position is reported only with an ok status.
  `PLE_ASSERT(a_found_ok, found_any |-> found_ok, "found position with bad status")

  // A full status comes only with a full list.
  `PLE_ASSERT(a_full_count, full_rsp |-> at_depth, "full status with short list")

endmodule

bind positional_list_engine_unit plist_checker #(.DEPTH(DEPTH)) u_plist_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

[dv/testbench.sv]
// Self-checking testbench for the positional list engine: random and directed requests.
module testbench;
  import plist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // Mode 3 has no meaning in the block and must answer as a bad position.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LONG_HOLD = 60;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_ITEMS = 48;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  // Idling controls shared by the driver, the receiver and the stimulus.
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  // Keeps its own copy of the list and the responses it still awaits.
  class plist_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int fill;
    rsp_t awaited_rsp_q[$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function int size_now();
      return fill;
    endfunction

    function logic signed [31:0] entry_at(int idx);
      return slots[idx];
    endfunction

    function int pending();
      return awaited_rsp_q.size();
    endfunction

    // Apply one accepted request to the list copy and queue its response.
    function void note_request(req_t r);
      rsp_t e;
      int pos;
      pos = int'(r.position);
      e.status = ST_BAD_POS;
      e.found_position = '0;
      case (r.mode)
        MODE_INSERT: begin
          if (pos == 0 || pos > fill + 1) begin
            e.status = ST_BAD_POS;
          end else if (fill >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            for (int i = fill; i >= pos; i--) slots[i] = slots[i - 1];
            slots[pos - 1] = r.value;
            fill++;
            e.status = ST_OK;
          end
        end
        MODE_REMOVE: begin
          if (pos == 0 || pos > fill) begin
            e.status = ST_BAD_POS;
          end else begin
            for (int i = pos; i < fill; i++) slots[i - 1] = slots[i];
            fill--;
            e.status = ST_OK;
          end
        end
        MODE_FIND: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.status = ST_NOT_FOUND;
            for (int i = 0; i < fill; i++) begin
              if (slots[i] == r.value) begin
                e.found_position = 5'(i + 1);
                e.status = ST_OK;
                break;
              end
            end
          end
        end
        default: e.status = ST_BAD_POS;
      endcase
      e.entry_count = 5'(fill);
      awaited_rsp_q.push_back(e);
    endfunction

    // Compare one accepted response with the oldest awaited one.
    task check_response(rsp_t got);
      rsp_t e;
      if (awaited_rsp_q.size() == 0) begin
        report($sformatf("response %p with no request outstanding", got));
      end else begin
        e = awaited_rsp_q.pop_front();
        if (got.status !== e.status)
          report($sformatf("status got %0d want %0d", got.status, e.status));
        if (got.found_position !== e.found_position)
          report($sformatf("found_position got %0d want %0d",
                           got.found_position, e.found_position));
        if (got.entry_count !== e.entry_count)
          report($sformatf("entry_count got %0d want %0d",
                           got.entry_count, e.entry_count));
      end
    endtask
  endclass

  plist_scoreboard sb = new();

  positional_list_engine_unit #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: note requests and check responses at each accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int burst_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = burst_length();
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request after an optional gap; returns at the falling edge after acceptance.
  task automatic send_request(input req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? burst_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every awaited response has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  function automatic req_t pack_req(logic [1:0] m, logic [4:0] p, logic [31:0] v);
    req_t r;
    r.mode = m;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  // Mostly well-formed requests against the current list, biased to grow or shrink it.
  function automatic req_t make_request(bit grow);
    req_t r;
    int n;
    int roll;
    n = sb.size_now();
    roll = $urandom_range(0, 99);
    if (roll < 4) r.mode = MODE_UNUSED;
    else if (roll < (grow ? 55 : 30)) r.mode = MODE_INSERT;
    else if (roll < 75) r.mode = MODE_REMOVE;
    else r.mode = MODE_FIND;

    if ($urandom_range(0, 99) < 12) r.position = 5'($urandom_range(0, 31));
    else if (r.mode == MODE_INSERT) r.position = 5'($urandom_range(1, n + 1));
    else if (r.mode == MODE_REMOVE && n > 0) r.position = 5'($urandom_range(1, n));
    else r.position = 5'($urandom_range(0, 31));

    // Searches often target a stored value; small values make duplicates likely.
    if (r.mode == MODE_FIND && n > 0 && $urandom_range(0, 99) < 60)
      r.value = sb.entry_at($urandom_range(0, n - 1));
    else if ($urandom_range(0, 99) < 30)
      r.value = 32'(int'($urandom_range(0, 15)) - 8);
    else
      r.value = $urandom;
    return r;
  endfunction

  // Main stimulus.
  initial begin : stimulus
    logic [31:0] v;
    int p;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-list cases and bad positions.
    send_request(pack_req(MODE_FIND, 5'd0, 32'd5));
    send_request(pack_req(MODE_REMOVE, 5'd1, 32'd0));
    send_request(pack_req(MODE_INSERT, 5'd0, 32'd1));
    send_request(pack_req(MODE_INSERT, 5'd2, 32'd1));

    // Directed: fill to capacity at front, back and middle, with extreme values.
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        default: v = $urandom;
      endcase
      p = (k % 3 == 0) ? 1 : (k % 3 == 1) ? k + 1 : k / 2 + 1;
      send_request(pack_req(MODE_INSERT, 5'(p), v));
    end

    // Directed: full list, searches, removes at the ends and the unused mode.
    send_request(pack_req(MODE_INSERT, 5'd17, 32'd9));
    send_request(pack_req(MODE_INSERT, 5'd31, 32'd9));
    send_request(pack_req(MODE_FIND, 5'd0, 32'h8000_0000));
    send_request(pack_req(MODE_REMOVE, 5'd17, 32'd0));
    send_request(pack_req(MODE_REMOVE, 5'd16, 32'd0));
    send_request(pack_req(MODE_REMOVE, 5'd1, 32'd0));
    send_request(pack_req(MODE_UNUSED, 5'd31, 32'hffff_ffff));
    send_request(pack_req(MODE_FIND, 5'd31, 32'h1234_5678));
    wait_drained();

    // Random: blocks alternate between growing and shrinking the list.
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 30; stall_pct = 30; end
        2: begin send_idle_pct = 10; stall_pct = 50; end
        default: begin send_idle_pct = 50; stall_pct = 10; end
      endcase
      // Long receiver hold-off while the sender keeps offering back to back.
      if (b == 5) begin
        send_idle_pct = 0;
        hold_request = 1'b1;
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        send_request(make_request(b % 2 == 0));
        if (b == 8 && n == BLOCK_ITEMS / 2) wait_drained();
      end
    end

    // Drain and let the last response settle.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/plist_pkg.sv
sv/plist_cell.sv
sv/positional_list_engine_unit.sv
sv/plist_checker.sv
dv/testbench.sv
